[rtl/core/r3000_instruction_classifier_unit_defines.svh]
// Assertion macros shared by the instruction classifier checkers.
// Depends on nothing; included by the checker file by its bare name.
`ifndef R3000_INSTRUCTION_CLASSIFIER_UNIT_DEFINES_SVH
`define R3000_INSTRUCTION_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define RIC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define RIC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ric_pkg.sv]
// Shared types, codes and helpers for the R3000 instruction classifier.
// Depends on nothing; imported by every module of the block.
package ric_pkg;

    // Stream payload widths (fields packed from bit 0, padded to bytes).
    localparam int IN_DATA_W  = 64;
    localparam int OUT_USED_W = 82;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Mnemonic codes, pseudo-instructions included.
    typedef enum logic [6:0] {
        MN_NOP, MN_SLL, MN_MOVE, MN_SRL, MN_SRA, MN_SLLV, MN_SRLV, MN_SRAV,
        MN_JR, MN_JALR, MN_SYSCALL, MN_MFHI, MN_MTHI, MN_MFLO, MN_MTLO,
        MN_MULT, MN_MULTU, MN_DIV, MN_DIVU, MN_ADD, MN_ADDU, MN_SUB, MN_NEG,
        MN_SUBU, MN_NEGU, MN_AND, MN_OR, MN_XOR, MN_NOT, MN_NOR, MN_SLT,
        MN_SLTU, MN_BLTZ, MN_BGEZ, MN_BLTZAL, MN_BGEZAL, MN_J, MN_JAL, MN_B,
        MN_BEQ, MN_BNE, MN_BLEZ, MN_BGTZ, MN_ADDI, MN_LI, MN_ADDIU, MN_SLTI,
        MN_SLTIU, MN_ANDI, MN_ORI, MN_XORI, MN_LUI, MN_MFC0, MN_MTC0, MN_RFE,
        MN_LB, MN_LH, MN_LWL, MN_LW, MN_LBU, MN_LHU, MN_LWR, MN_SB, MN_SH,
        MN_SWL, MN_SW, MN_SWR
    } mnem_t;

    // Operand layout codes.
    typedef enum logic [4:0] {
        FM_NONE, FM_DH, FM_DT, FM_DTH, FM_DS, FM_DTS, FM_S, FM_D, FM_ST,
        FM_DST, FM_SB, FM_J, FM_B, FM_STB, FM_TI, FM_TS, FM_TSI, FM_TCD,
        FM_TMEM0, FM_TMEM
    } form_t;

    // Classification handed from the decoder to the target unit and output.
    typedef struct packed {
        logic  ok;
        mnem_t mn;
        form_t form;
        logic  delay;
    } cls_t;

    // Major opcodes, bits 31..26.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    // Loads and stores occupy opcodes 0x20 to 0x2F.
    localparam logic [1:0] OP_MEM_HI  = 2'b10;

    // Function codes of the special opcode, bits 5..0.
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // Register-immediate branch selectors in the rt field.
    localparam logic [4:0] RT_BLTZ    = 5'h00;
    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_BGEZAL  = 5'h11;

    // Coprocessor 0 selectors in the rs field.
    localparam logic [4:0] CP0_MF     = 5'h00;
    localparam logic [4:0] CP0_MT     = 5'h04;
    localparam logic [4:0] CP0_RFE    = 5'h10;

    // Jump target region kept from the PC.
    localparam int REGION_W = 4;

    // Build a recognized classification.
    function automatic cls_t mk_cls(mnem_t mn, form_t form, logic delay);
        cls_t c;
        c.ok    = 1'b1;
        c.mn    = mn;
        c.form  = form;
        c.delay = delay;
        return c;
    endfunction

    // Classification of an unrecognized word.
    localparam cls_t CLS_BAD = '{ok: 1'b0, mn: MN_NOP, form: FM_NONE, delay: 1'b0};

endpackage

[rtl/core/r3000_instruction_classifier_unit.sv]
// Top level of the R3000 instruction classifier: input register, decoder,
// target unit and result register. Depends on ric_pkg, ric_decode, ric_target.
//
//  Channel  | Direction | tdata fields (low bit first)          | Width
//  ---------+-----------+---------------------------------------+------
//  s_axis   | in        | pc, insn                              | 64
//  m_axis   | out       | valid_res .. has_delay_slot, 6 pad    | 88
//
// An accepted request is held in the input register, which feeds the decoder
// and the target adder, whose output loads the result register that drives
// m_axis. One request is accepted per cycle while m_axis is not stalled.
// Each stage refills in the cycle it empties, so a stall on m_axis holds
// both stages and drops s_axis_tready only when both are full.
// Reset (aresetn low, synchronous) empties both stages.
module r3000_instruction_classifier_unit
    import ric_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] pc, [63:32] insn
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] valid_res, [7:1] mnemonic_code, [12:8] form_code, [17:13] reg_s,
    // [22:18] reg_t, [27:23] reg_d, [32:28] shift_amount, [48:33] immediate,
    // [80:49] target_address, [81] has_delay_slot, [87:82] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [31:0]           pc_reg;
    logic [31:0]           insn_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_load;
    logic                  in_load;
    cls_t                  cls;
    logic [31:0]           target;

    // Each stage may load when it is empty or when its content moves on.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            pc_reg   <= s_axis_tdata[31:0];
            insn_reg <= s_axis_tdata[63:32];
        end
    end

    ric_decode u_decode (
        .insn (insn_reg),
        .cls  (cls)
    );

    ric_target u_target (
        .pc     (pc_reg),
        .insn   (insn_reg),
        .cls    (cls),
        .target (target)
    );

    // Pack the result; an invalid word already carries zero codes and target.
    assign out_data_next = {
        {OUT_PAD_W{1'b0}},
        cls.delay,
        target,
        insn_reg[15:0],
        insn_reg[10:6],
        insn_reg[15:11],
        insn_reg[20:16],
        insn_reg[25:21],
        cls.form,
        cls.mn,
        cls.ok
    };

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/core/ric_decode.sv]
// Instruction decoder: maps one instruction word to mnemonic, operand form,
// validity and delay-slot flag. Depends on ric_pkg.
module ric_decode
    import ric_pkg::*;
(
    input  logic [31:0] insn,
    output cls_t        cls
);

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [4:0] sa;
    logic [15:0] imm;
    logic [3:0] mem_sel;

    assign op  = insn[31:26];
    assign fn  = insn[5:0];
    assign rs  = insn[25:21];
    assign rt  = insn[20:16];
    assign rd  = insn[15:11];
    assign sa  = insn[10:6];
    assign imm = insn[15:0];
    assign mem_sel = insn[29:26];

    // Special opcode: the function field picks the operation, and operand
    // rules pick the pseudo-instruction aliases.
    cls_t special_cls;
    always_comb begin
        mnem_t sh_mn;
        mnem_t sv_mn;
        mnem_t ad_mn;
        mnem_t sb_mn;
        mnem_t ng_mn;
        mnem_t lo_mn;
        sh_mn = (fn == FN_SLL) ? MN_SLL : ((fn == FN_SRL) ? MN_SRL : MN_SRA);
        sv_mn = (fn == FN_SLLV) ? MN_SLLV : ((fn == FN_SRLV) ? MN_SRLV : MN_SRAV);
        ad_mn = (fn == FN_ADD) ? MN_ADD : MN_ADDU;
        sb_mn = (fn == FN_SUB) ? MN_SUB : MN_SUBU;
        ng_mn = (fn == FN_SUB) ? MN_NEG : MN_NEGU;
        lo_mn = (fn == FN_OR) ? MN_OR : MN_XOR;
        special_cls = CLS_BAD;
        case (fn)
            FN_SLL, FN_SRL, FN_SRA: begin
                if (insn == 32'h0)  special_cls = mk_cls(MN_NOP, FM_NONE, 1'b0);
                else if (rd == rt)  special_cls = mk_cls(sh_mn, FM_DH, 1'b0);
                else if (sa == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DT, 1'b0);
                else                special_cls = mk_cls(sh_mn, FM_DTH, 1'b0);
            end
            FN_SLLV, FN_SRLV, FN_SRAV: begin
                if (rd == rt)       special_cls = mk_cls(sv_mn, FM_DS, 1'b0);
                else if (rs == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DT, 1'b0);
                else                special_cls = mk_cls(sv_mn, FM_DTS, 1'b0);
            end
            FN_JR:      special_cls = mk_cls(MN_JR, FM_S, 1'b1);
            FN_JALR:    special_cls = mk_cls(MN_JALR, (rd == 5'd31) ? FM_S : FM_DS, 1'b1);
            FN_SYSCALL: special_cls = mk_cls(MN_SYSCALL, FM_NONE, 1'b0);
            FN_MFHI:    special_cls = mk_cls(MN_MFHI, FM_D, 1'b0);
            FN_MTHI:    special_cls = mk_cls(MN_MTHI, FM_S, 1'b0);
            FN_MFLO:    special_cls = mk_cls(MN_MFLO, FM_D, 1'b0);
            FN_MTLO:    special_cls = mk_cls(MN_MTLO, FM_S, 1'b0);
            FN_MULT:    special_cls = mk_cls(MN_MULT, FM_ST, 1'b0);
            FN_MULTU:   special_cls = mk_cls(MN_MULTU, FM_ST, 1'b0);
            FN_DIV:     special_cls = mk_cls(MN_DIV, FM_ST, 1'b0);
            FN_DIVU:    special_cls = mk_cls(MN_DIVU, FM_ST, 1'b0);
            FN_ADD, FN_ADDU: begin
                if (rd == rs)       special_cls = mk_cls(ad_mn, FM_DT, 1'b0);
                else if (rt == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DS, 1'b0);
                else if (rs == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DT, 1'b0);
                else                special_cls = mk_cls(ad_mn, FM_DST, 1'b0);
            end
            FN_SUB, FN_SUBU: begin
                if (rd == rs)       special_cls = mk_cls(sb_mn, FM_DT, 1'b0);
                else if (rt == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DS, 1'b0);
                else if (rs == 5'd0) begin
                    special_cls = mk_cls(ng_mn, (rd == rt) ? FM_D : FM_DT, 1'b0);
                end else begin
                    special_cls = mk_cls(sb_mn, FM_DST, 1'b0);
                end
            end
            FN_AND:     special_cls = mk_cls(MN_AND, (rd == rs) ? FM_DT : FM_DST, 1'b0);
            FN_OR, FN_XOR: begin
                if (rd == rs)       special_cls = mk_cls(lo_mn, FM_DT, 1'b0);
                else if (rt == 5'd0) special_cls = mk_cls(MN_MOVE, FM_DS, 1'b0);
                else                special_cls = mk_cls(lo_mn, FM_DST, 1'b0);
            end
            FN_NOR: begin
                if (rt == 5'd0) begin
                    special_cls = mk_cls(MN_NOT, (rd == rs) ? FM_D : FM_DS, 1'b0);
                end else if (rs == 5'd0) begin
                    special_cls = mk_cls(MN_NOT, (rd == rt) ? FM_D : FM_DT, 1'b0);
                end else begin
                    special_cls = mk_cls(MN_NOR, (rd == rs) ? FM_DT : FM_DST, 1'b0);
                end
            end
            FN_SLT:     special_cls = mk_cls(MN_SLT, FM_DST, 1'b0);
            FN_SLTU:    special_cls = mk_cls(MN_SLTU, FM_DST, 1'b0);
            default:    special_cls = CLS_BAD;
        endcase
    end

    // Loads and stores: the low four opcode bits select the access; the
    // form drops the offset when it is zero.
    cls_t mem_cls;
    always_comb begin
        form_t mf;
        mf = (imm == 16'h0) ? FM_TMEM0 : FM_TMEM;
        mem_cls = CLS_BAD;
        case (mem_sel)
            4'h0:    mem_cls = mk_cls(MN_LB, mf, 1'b0);
            4'h1:    mem_cls = mk_cls(MN_LH, mf, 1'b0);
            4'h2:    mem_cls = mk_cls(MN_LWL, mf, 1'b0);
            4'h3:    mem_cls = mk_cls(MN_LW, mf, 1'b0);
            4'h4:    mem_cls = mk_cls(MN_LBU, mf, 1'b0);
            4'h5:    mem_cls = mk_cls(MN_LHU, mf, 1'b0);
            4'h6:    mem_cls = mk_cls(MN_LWR, mf, 1'b0);
            4'h8:    mem_cls = mk_cls(MN_SB, mf, 1'b0);
            4'h9:    mem_cls = mk_cls(MN_SH, mf, 1'b0);
            4'hA:    mem_cls = mk_cls(MN_SWL, mf, 1'b0);
            4'hB:    mem_cls = mk_cls(MN_SW, mf, 1'b0);
            4'hE:    mem_cls = mk_cls(MN_SWR, mf, 1'b0);
            default: mem_cls = CLS_BAD;
        endcase
    end

    // Major opcodes other than special.
    cls_t major_cls;
    always_comb begin
        mnem_t ai_mn;
        form_t ts_form;
        ai_mn = (op == OP_ADDI) ? MN_ADDI : MN_ADDIU;
        ts_form = (rt == rs) ? FM_TI : FM_TSI;
        major_cls = CLS_BAD;
        case (op)
            OP_REGIMM: begin
                case (rt)
                    RT_BLTZ:   major_cls = mk_cls(MN_BLTZ, FM_SB, 1'b1);
                    RT_BGEZ:   major_cls = mk_cls(MN_BGEZ, FM_SB, 1'b1);
                    RT_BLTZAL: major_cls = mk_cls(MN_BLTZAL, FM_SB, 1'b1);
                    RT_BGEZAL: major_cls = mk_cls(MN_BGEZAL, FM_SB, 1'b1);
                    default:   major_cls = CLS_BAD;
                endcase
            end
            OP_J:    major_cls = mk_cls(MN_J, FM_J, 1'b1);
            OP_JAL:  major_cls = mk_cls(MN_JAL, FM_J, 1'b1);
            OP_BEQ: begin
                if (rs == rt) major_cls = mk_cls(MN_B, FM_B, 1'b1);
                else          major_cls = mk_cls(MN_BEQ, FM_STB, 1'b1);
            end
            OP_BNE:  major_cls = mk_cls(MN_BNE, FM_STB, 1'b1);
            OP_BLEZ: begin
                if (rs == 5'd0) major_cls = mk_cls(MN_B, FM_B, 1'b1);
                else            major_cls = mk_cls(MN_BLEZ, FM_SB, 1'b1);
            end
            OP_BGTZ: major_cls = mk_cls(MN_BGTZ, FM_SB, 1'b1);
            OP_ADDI, OP_ADDIU: begin
                if (rt == rs)          major_cls = mk_cls(ai_mn, FM_TI, 1'b0);
                else if (rs == 5'd0)   major_cls = mk_cls(MN_LI, FM_TI, 1'b0);
                else if (imm == 16'h0) major_cls = mk_cls(MN_MOVE, FM_TS, 1'b0);
                else                   major_cls = mk_cls(ai_mn, FM_TSI, 1'b0);
            end
            OP_SLTI:  major_cls = mk_cls(MN_SLTI, FM_TSI, 1'b0);
            OP_SLTIU: major_cls = mk_cls(MN_SLTIU, FM_TSI, 1'b0);
            OP_ANDI:  major_cls = mk_cls(MN_ANDI, ts_form, 1'b0);
            OP_ORI:   major_cls = mk_cls(MN_ORI, ts_form, 1'b0);
            OP_XORI:  major_cls = mk_cls(MN_XORI, ts_form, 1'b0);
            OP_LUI:   major_cls = mk_cls(MN_LUI, FM_TI, 1'b0);
            OP_COP0: begin
                case (rs)
                    CP0_MF:  major_cls = mk_cls(MN_MFC0, FM_TCD, 1'b0);
                    CP0_MT:  major_cls = mk_cls(MN_MTC0, FM_TCD, 1'b0);
                    CP0_RFE: major_cls = mk_cls(MN_RFE, FM_NONE, 1'b0);
                    default: major_cls = CLS_BAD;
                endcase
            end
            default: begin
                if (op[5:4] == OP_MEM_HI) major_cls = mem_cls;
                else                      major_cls = CLS_BAD;
            end
        endcase
    end

    // The special opcode owns every word below the first major opcode.
    assign cls = (op == OP_SPECIAL) ? special_cls : major_cls;

endmodule

[rtl/core/ric_target.sv]
// Branch and jump target unit: a 32-bit pc + 4 + offset sum for PC-relative
// branches, a region splice for absolute jumps. Depends on ric_pkg.
module ric_target
    import ric_pkg::*;
(
    input  logic [31:0] pc,
    input  logic [31:0] insn,
    input  cls_t        cls,
    output logic [31:0] target
);

    logic [31:0] branch_off;
    logic [31:0] branch_tgt;
    logic [31:0] jump_tgt;

    // Sign-extended word offset, then pc + 4 + offset, wrapping at 2^32.
    assign branch_off = {{14{insn[15]}}, insn[15:0], 2'b00};
    assign branch_tgt = pc + 32'd4 + branch_off;

    // Absolute jump within the current 256 MB region.
    assign jump_tgt = {pc[31:32-REGION_W], insn[25:0], 2'b00};

    // Only valid branch and jump forms carry a target.
    always_comb begin
        target = 32'h0;
        if (cls.ok) begin
            case (cls.form)
                FM_SB, FM_B, FM_STB: target = branch_tgt;
                FM_J:                target = jump_tgt;
                default:             target = 32'h0;
            endcase
        end
    end

endmodule

[rtl/core/ric_checker.sv]
// Port-level checker for the R3000 instruction classifier, bound to the top.
// Depends on ric_pkg and r3000_instruction_classifier_unit_defines.svh.
`include "r3000_instruction_classifier_unit_defines.svh"

module ric_checker
    import ric_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  vld;
    logic [OUT_DATA_W-1:0] res;
    logic                  stall;
    logic                  bad_word;
    logic                  no_slot;
    logic                  codes_zero;
    logic                  tgt_zero;
    logic                  in_range;

    // Short views of the result channel for the checks below.
    assign vld        = m_axis_tvalid;
    assign res        = m_axis_tdata;
    assign stall      = vld && !m_axis_tready;
    assign bad_word   = vld && !res[0];
    assign no_slot    = vld && !res[81];
    assign codes_zero = (res[12:1] == 12'h0) && (res[81:49] == 33'h0);
    assign tgt_zero   = (res[80:49] == 32'h0);
    assign in_range   = (res[7:1] <= 7'd66) && (res[87:82] == 6'h0);

    // A stalled result stays offered and unchanged.
    `RIC_ASSERT_NEXT(a_out_hold, aclk, aresetn, stall, vld && $stable(res), "result changed")

    // An unrecognized word reports no mnemonic, form, target or delay slot.
    `RIC_ASSERT_NOW(a_invalid_zero, aclk, aresetn, bad_word, codes_zero, "codes on invalid word")

    // Only instructions with a delay slot carry a target address.
    `RIC_ASSERT_NOW(a_target_delay, aclk, aresetn, no_slot, tgt_zero, "target without delay slot")

    // Mnemonic codes stay in range and the padding stays zero.
    `RIC_ASSERT_NOW(a_code_range, aclk, aresetn, vld, in_range, "code out of range or pad set")

    // A ready result side always lets a new request in.
    `RIC_ASSERT_NOW(a_ready_pass, aclk, aresetn, m_axis_tready, s_axis_tready, "input blocked")

endmodule

bind r3000_instruction_classifier_unit ric_checker u_ric_checker (.*);
